// ----- sv/rsh_pkg.sv -----
// ============================================================================
// rsh_pkg: shared types, constants and tables for the spherical harmonic block
// Fixed-point constants, CORDIC arctangent table, Legendre recurrence
// coefficient tables and the sequencer state type.
// ============================================================================
`default_nettype none

package rsh_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DEGREE_DEF = 8;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Internal number format: signed Q30 in a 34-bit word
    localparam int QW         = 34;
    localparam int ZW         = 33;
    localparam int CW         = 32;
    localparam int Q_SHIFT    = 30;
    localparam int COEF_SHIFT = 24;
    localparam int CORDIC_STEPS = 30;
    localparam int TAB_N      = 16;
    localparam int OUT_W      = 20;

    localparam logic [30:0]          HALF_PI_Q30     = 31'd1686629713;
    localparam logic signed [QW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [QW-1:0] INV_SQRT_4PI_Q30 = 34'sd302896976;
    localparam logic signed [QW-1:0] SQRT2_Q30       = 34'sd1518500250;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef logic [CW-1:0]                        t_coef;
    typedef logic [TAB_N-1:0][CW-1:0]             t_coef_row;
    typedef logic [TAB_N-1:0][TAB_N-1:0][CW-1:0]  t_coef_sq;

    // One beat travelling down the CORDIC chain
    typedef struct packed {
        logic                 valid;
        logic                 tag;
        logic [1:0]           quad;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    typedef enum logic [3:0] {
        S_IDLE, S_FEED_TH, S_FEED_PH, S_WAIT,
        S_SEC_A, S_SEC_B, S_P1_A, S_P1_B,
        S_REC_A, S_REC_B, S_REC_C, S_AZ_A, S_AZ_B, S_RND
    } t_state;

    // floor(sqrt(num * 2^48 / den)): largest r with r*r*den <= num * 2^48
    function automatic t_coef coef_q24(input longint unsigned num,
                                       input longint unsigned den);
        logic [127:0] tgt;
        logic [127:0] sq;
        logic [31:0]  r;
        logic [31:0]  trial;
        tgt = {64'd0, num} << 48;
        r   = '0;
        if (den == 0) begin
            return '0;
        end
        for (int i = 31; i >= 0; i--) begin
            trial = r | (32'd1 << i);
            sq    = {96'd0, trial} * {96'd0, trial} * {64'd0, den};
            if (sq <= tgt) begin
                r = trial;
            end
        end
        return r;
    endfunction

    function automatic t_coef_sq build_a();
        t_coef_sq t;
        t = '0;
        for (int ll = 1; ll < TAB_N; ll++) begin
            for (int am = 0; am < ll; am++) begin
                t[ll][am] = coef_q24(longint'(4 * ll * ll - 1), longint'(ll * ll - am * am));
            end
        end
        return t;
    endfunction

    function automatic t_coef_sq build_b();
        t_coef_sq t;
        t = '0;
        for (int ll = 2; ll < TAB_N; ll++) begin
            for (int am = 0; am <= ll - 2; am++) begin
                t[ll][am] = coef_q24(longint'((ll - 1) * (ll - 1) - am * am),
                                     longint'(4 * (ll - 1) * (ll - 1) - 1));
            end
        end
        return t;
    endfunction

    function automatic t_coef_row build_cs();
        t_coef_row t;
        t = '0;
        for (int k = 1; k < TAB_N; k++) begin
            t[k] = coef_q24(longint'(2 * k + 1), longint'(2 * k));
        end
        return t;
    endfunction

    function automatic t_coef_row build_cp();
        t_coef_row t;
        t = '0;
        for (int am = 0; am < TAB_N; am++) begin
            t[am] = coef_q24(longint'(2 * am + 3), 64'd1);
        end
        return t;
    endfunction

    localparam t_coef_sq  A_TAB  = build_a();
    localparam t_coef_sq  B_TAB  = build_b();
    localparam t_coef_row CS_TAB = build_cs();
    localparam t_coef_row CP_TAB = build_cp();

endpackage

`default_nettype wire

// ----- sv/rsh_cordic_cell.sv -----
// ============================================================================
// rsh_cordic_cell: one rotation step of the CORDIC chain
// Rotates by the arctangent of 2^-IDX towards zero residual angle and
// registers the beat for the next cell.
// ============================================================================
`default_nettype none

module rsh_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rsh_pkg::t_cord i_cord,
    output rsh_pkg::t_cord      o_cord
);

    rsh_pkg::t_cord r_cord;
    rsh_pkg::t_cord n_cord;

    logic signed [rsh_pkg::QW-1:0] sx;
    logic signed [rsh_pkg::QW-1:0] sy;
    logic signed [rsh_pkg::ZW-1:0] ang;

    always_comb begin
        sx  = i_cord.x >>> IDX;
        sy  = i_cord.y >>> IDX;
        ang = $signed({1'b0, rsh_pkg::ATAN_TAB[IDX]});
        n_cord = i_cord;
        if (!i_cord.z[rsh_pkg::ZW-1]) begin
            n_cord.x = i_cord.x - sy;
            n_cord.y = i_cord.y + sx;
            n_cord.z = i_cord.z - ang;
        end else begin
            n_cord.x = i_cord.x + sy;
            n_cord.y = i_cord.y - sx;
            n_cord.z = i_cord.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cord.valid <= 1'b0;
        end else begin
            r_cord.valid <= n_cord.valid;
        end
        r_cord.tag  <= n_cord.tag;
        r_cord.quad <= n_cord.quad;
        r_cord.x    <= n_cord.x;
        r_cord.y    <= n_cord.y;
        r_cord.z    <= n_cord.z;
    end

    assign o_cord = r_cord;

endmodule

`default_nettype wire

// ----- sv/rsh_mul_round.sv -----
// ============================================================================
// rsh_mul_round: shared signed multiplier with round-half-up shift
// Multiplies two Q words and drops 30 or 24 fraction bits after adding
// half an LSB.
// ============================================================================
`default_nettype none

module rsh_mul_round (
    input  wire logic signed [rsh_pkg::QW-1:0] i_a,
    input  wire logic signed [rsh_pkg::QW-1:0] i_b,
    input  wire logic                          i_coef,
    output logic signed [rsh_pkg::QW-1:0]      o_p
);

    localparam int PW = 2 * rsh_pkg::QW;
    localparam logic signed [PW-1:0] HALF_Q = PW'(1) <<< (rsh_pkg::Q_SHIFT - 1);
    localparam logic signed [PW-1:0] HALF_C = PW'(1) <<< (rsh_pkg::COEF_SHIFT - 1);

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;

    always_comb begin
        prod = i_a * i_b;
        if (i_coef) begin
            rnd = (prod + HALF_C) >>> rsh_pkg::COEF_SHIFT;
        end else begin
            rnd = (prod + HALF_Q) >>> rsh_pkg::Q_SHIFT;
        end
        o_p = rnd[rsh_pkg::QW-1:0];
    end

endmodule

`default_nettype wire

// ----- sv/real_spherical_harmonic_basis.sv -----
// ============================================================================
// real_spherical_harmonic_basis: real spherical harmonic Y_lm(theta, phi)
// Thirty-cell CORDIC chain for the angles, shared multiplier sequencer for
// the normalised Legendre recurrence and the azimuthal factor.
// ============================================================================
// When |m| > l the result goes straight to rounding. Otherwise theta and
//   phi pass the CORDIC chain, then the single multiplier that all steps
//   share runs the sectoral steps for |m|, the recurrence when l > |m|,
//   the azimuthal factor when m /= 0, and the final rounding.
// Throughput: one item at a time; the next beat is taken once the result
//   sits in the output register. Synchronous active-low reset clears control.
`default_nettype none

module real_spherical_harmonic_basis #(
    parameter int MAX_DEGREE = rsh_pkg::MAX_DEGREE_DEF,
    parameter int ANGLE_BITS = rsh_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = rsh_pkg::FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [3:0]              i_degree,
    input  wire logic signed [4:0]       i_order,
    input  wire logic [ANGLE_BITS-1:0]   i_polar_angle,
    input  wire logic [ANGLE_BITS-1:0]   i_azimuth_angle,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [rsh_pkg::OUT_W-1:0] o_basis_value,
    output logic                         o_order_out_of_range
);

    localparam int QW   = rsh_pkg::QW;
    localparam int UW   = ANGLE_BITS + 1;
    localparam int RB   = ANGLE_BITS - 1;
    localparam int ZPW  = RB + 31;
    localparam int RSH  = rsh_pkg::Q_SHIFT - FRAC_BITS;
    localparam int NC   = rsh_pkg::CORDIC_STEPS;
    localparam logic signed [QW-1:0] SAT_HI = QW'((1 <<< (rsh_pkg::OUT_W - 1)) - 1);
    localparam logic signed [QW-1:0] SAT_LO = -QW'(1 <<< (rsh_pkg::OUT_W - 1));

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rsh_pkg::t_state r_state, n_state;
    logic [3:0]           r_l, n_l;
    logic signed [4:0]    r_m, n_m;
    logic [3:0]           r_am, n_am;
    logic [3:0]           r_k, n_k;
    logic                 r_oor, n_oor;
    logic [UW-1:0]        r_th_u, n_th_u;
    logic [UW-1:0]        r_ph_u, n_ph_u;
    logic signed [QW-1:0] r_c, n_c;
    logic signed [QW-1:0] r_s, n_s;
    logic signed [QW-1:0] r_pc, n_pc;
    logic signed [QW-1:0] r_ps, n_ps;
    logic signed [QW-1:0] r_p0, n_p0;
    logic signed [QW-1:0] r_p1, n_p1;
    logic signed [QW-1:0] r_t, n_t;
    logic signed [QW-1:0] r_y, n_y;
    logic                 r_o_valid, n_o_valid;
    logic signed [rsh_pkg::OUT_W-1:0] r_o_basis, n_o_basis;
    logic                 r_o_flag, n_o_flag;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic [3:0]            l_sat;
    logic [4:0]            am_in;
    logic [ANGLE_BITS+3:0] ph_prod;

    always_comb begin
        l_sat   = (i_degree > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : i_degree;
        am_in   = i_order[4] ? 5'(-i_order) : i_order;
        ph_prod = am_in[3:0] * i_azimuth_angle;
    end

    // ------------------------------------------------------------------
    // CORDIC chain: feed theta then phi, one beat each
    // ------------------------------------------------------------------
    rsh_pkg::t_cord chain [NC+1];
    rsh_pkg::t_cord chain_in;
    logic [UW-1:0]  feed_u;
    logic [ZPW-1:0] feed_zp;

    always_comb begin
        feed_u  = (r_state == rsh_pkg::S_FEED_PH) ? r_ph_u : r_th_u;
        feed_zp = feed_u[RB-1:0] * rsh_pkg::HALF_PI_Q30;
        chain_in.valid = (r_state == rsh_pkg::S_FEED_TH) || (r_state == rsh_pkg::S_FEED_PH);
        chain_in.tag   = (r_state == rsh_pkg::S_FEED_PH);
        chain_in.quad  = feed_u[RB+1:RB];
        chain_in.x     = rsh_pkg::CORDIC_GAIN_Q30;
        chain_in.y     = '0;
        chain_in.z     = rsh_pkg::ZW'(feed_zp >> RB);
    end

    assign chain[0] = chain_in;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        rsh_cordic_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cord  (chain[g]),
            .o_cord  (chain[g+1])
        );
    end

    // Fold the quadrant back in
    logic signed [QW-1:0] qc, qs;

    always_comb begin
        unique case (chain[NC].quad)
            2'd0: begin qc = chain[NC].x;  qs = chain[NC].y;  end
            2'd1: begin qc = -chain[NC].y; qs = chain[NC].x;  end
            2'd2: begin qc = -chain[NC].x; qs = -chain[NC].y; end
            default: begin qc = chain[NC].y; qs = -chain[NC].x; end
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic signed [QW-1:0] mul_a, mul_b, mul_p;
    logic                 mul_coef;

    rsh_mul_round u_mul (
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_coef (mul_coef),
        .o_p    (mul_p)
    );

    // ------------------------------------------------------------------
    // Final rounding to the output fraction and saturation
    // ------------------------------------------------------------------
    logic signed [QW-1:0] y_rnd;
    logic signed [rsh_pkg::OUT_W-1:0] y_sat;

    if (RSH > 0) begin : g_rnd
        always_comb y_rnd = (r_y + (QW'(1) <<< (RSH - 1))) >>> RSH;
    end else begin : g_nornd
        always_comb y_rnd = r_y;
    end

    always_comb begin
        if (y_rnd < SAT_LO) begin
            y_sat = SAT_LO[rsh_pkg::OUT_W-1:0];
        end else if (y_rnd > SAT_HI) begin
            y_sat = SAT_HI[rsh_pkg::OUT_W-1:0];
        end else begin
            y_sat = y_rnd[rsh_pkg::OUT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    rsh_pkg::t_state st_fin;

    always_comb begin
        n_state = r_state;
        n_l = r_l; n_m = r_m; n_am = r_am; n_k = r_k; n_oor = r_oor;
        n_th_u = r_th_u; n_ph_u = r_ph_u;
        n_c = r_c; n_s = r_s; n_pc = r_pc; n_ps = r_ps;
        n_p0 = r_p0; n_p1 = r_p1; n_t = r_t; n_y = r_y;
        n_o_valid = r_o_valid; n_o_basis = r_o_basis; n_o_flag = r_o_flag;
        mul_a = r_p0; mul_b = r_s; mul_coef = 1'b0;
        st_fin = (r_m != '0) ? rsh_pkg::S_AZ_A : rsh_pkg::S_RND;

        // drop the result once downstream takes it
        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        // catch the angle results leaving the chain; theta sine cannot be negative
        if (chain[NC].valid) begin
            if (!chain[NC].tag) begin
                n_c = qc;
                n_s = qs[QW-1] ? '0 : qs;
            end else begin
                n_pc = qc;
                n_ps = qs;
            end
        end

        unique case (r_state)
            rsh_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_l    = l_sat;
                    n_m    = i_order;
                    n_am   = am_in[3:0];
                    n_oor  = am_in > {1'b0, l_sat};
                    n_th_u = {1'b0, i_polar_angle};
                    n_ph_u = {ph_prod[ANGLE_BITS-1:0], 1'b0};
                    n_state = (am_in > {1'b0, l_sat}) ? rsh_pkg::S_RND : rsh_pkg::S_FEED_TH;
                end
            end
            rsh_pkg::S_FEED_TH: n_state = rsh_pkg::S_FEED_PH;
            rsh_pkg::S_FEED_PH: n_state = rsh_pkg::S_WAIT;
            rsh_pkg::S_WAIT: begin
                if (chain[NC].valid && chain[NC].tag) begin
                    n_p0 = rsh_pkg::INV_SQRT_4PI_Q30;
                    n_k  = 4'd1;
                    if (r_am != '0) begin
                        n_state = rsh_pkg::S_SEC_A;
                    end else if (r_l != r_am) begin
                        n_state = rsh_pkg::S_P1_A;
                    end else begin
                        n_y     = rsh_pkg::INV_SQRT_4PI_Q30;
                        n_state = st_fin;
                    end
                end
            end
            rsh_pkg::S_SEC_A: begin
                mul_a = r_p0; mul_b = r_s;
                n_t = mul_p;
                n_state = rsh_pkg::S_SEC_B;
            end
            rsh_pkg::S_SEC_B: begin
                mul_a = r_t; mul_b = $signed({2'b00, rsh_pkg::CS_TAB[r_k]}); mul_coef = 1'b1;
                n_p0 = -mul_p;
                if (r_k == r_am) begin
                    if (r_l != r_am) begin
                        n_state = rsh_pkg::S_P1_A;
                    end else begin
                        n_y     = -mul_p;
                        n_state = st_fin;
                    end
                end else begin
                    n_k     = 4'(r_k + 4'd1);
                    n_state = rsh_pkg::S_SEC_A;
                end
            end
            rsh_pkg::S_P1_A: begin
                mul_a = r_p0; mul_b = r_c;
                n_t = mul_p;
                n_state = rsh_pkg::S_P1_B;
            end
            rsh_pkg::S_P1_B: begin
                mul_a = r_t; mul_b = $signed({2'b00, rsh_pkg::CP_TAB[r_am]}); mul_coef = 1'b1;
                n_p1 = mul_p;
                if (r_l == 4'(r_am + 4'd1)) begin
                    n_y     = mul_p;
                    n_state = st_fin;
                end else begin
                    n_k     = 4'(r_am + 4'd2);
                    n_state = rsh_pkg::S_REC_A;
                end
            end
            rsh_pkg::S_REC_A: begin
                mul_a = r_c; mul_b = r_p1;
                n_t = mul_p;
                n_state = rsh_pkg::S_REC_B;
            end
            rsh_pkg::S_REC_B: begin
                mul_a = $signed({2'b00, rsh_pkg::B_TAB[r_k][r_am]}); mul_b = r_p0;
                mul_coef = 1'b1;
                n_t = r_t - mul_p;
                n_state = rsh_pkg::S_REC_C;
            end
            rsh_pkg::S_REC_C: begin
                mul_a = r_t; mul_b = $signed({2'b00, rsh_pkg::A_TAB[r_k][r_am]});
                mul_coef = 1'b1;
                n_p0 = r_p1;
                n_p1 = mul_p;
                if (r_k == r_l) begin
                    n_y     = mul_p;
                    n_state = st_fin;
                end else begin
                    n_k     = 4'(r_k + 4'd1);
                    n_state = rsh_pkg::S_REC_A;
                end
            end
            rsh_pkg::S_AZ_A: begin
                // positive order takes the cosine, negative the sine
                mul_a = r_m[4] ? r_ps : r_pc; mul_b = rsh_pkg::SQRT2_Q30;
                n_t = mul_p;
                n_state = rsh_pkg::S_AZ_B;
            end
            rsh_pkg::S_AZ_B: begin
                mul_a = r_y; mul_b = r_t;
                n_y = mul_p;
                n_state = rsh_pkg::S_RND;
            end
            rsh_pkg::S_RND: begin
                // hold here until the output register is free
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid = 1'b1;
                    n_o_basis = r_oor ? '0 : y_sat;
                    n_o_flag  = r_oor;
                    n_state   = rsh_pkg::S_IDLE;
                end
            end
            default: n_state = rsh_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsh_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l <= n_l; r_m <= n_m; r_am <= n_am; r_k <= n_k; r_oor <= n_oor;
        r_th_u <= n_th_u; r_ph_u <= n_ph_u;
        r_c <= n_c; r_s <= n_s; r_pc <= n_pc; r_ps <= n_ps;
        r_p0 <= n_p0; r_p1 <= n_p1; r_t <= n_t; r_y <= n_y;
        r_o_basis <= n_o_basis; r_o_flag <= n_o_flag;
    end

    assign o_in_stall           = (r_state != rsh_pkg::S_IDLE);
    assign o_out_valid          = r_o_valid;
    assign o_basis_value        = r_o_basis;
    assign o_order_out_of_range = r_o_flag;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_order_out_of_range |-> o_basis_value == '0)
        else $error("out-of-range result carries a non-zero value");

    a_chain_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[NC].valid |-> r_state == rsh_pkg::S_WAIT)
        else $error("CORDIC beat left the chain outside the wait state");

    a_rec_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rsh_pkg::S_REC_A |-> (r_k <= r_l) && (r_k > r_am))
        else $error("recurrence degree out of bounds");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state != rsh_pkg::S_IDLE)
        else $error("accepted beat left the sequencer idle");

endmodule

`default_nettype wire
